>>> src/mct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_pkg
// shared types, widths and codes of the claimant state tracker
// ----------------------------------------------------------------------------
package mct_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int MSG_W = 8;
    localparam int MAC_W = 48;
    localparam int LEN_W = 16;
    localparam int CS_W  = 3;
    localparam int TOT_W = 32;

    typedef logic [CS_W-1:0] claim_state_t;

    // claim states
    localparam claim_state_t ST_UNKNOWN   = 3'd0;
    localparam claim_state_t ST_PROBING   = 3'd1;
    localparam claim_state_t ST_ACQUIRED  = 3'd2;
    localparam claim_state_t ST_DEFENDING = 3'd3;
    localparam claim_state_t ST_LOST      = 3'd4;

    // message types
    localparam logic [MSG_W-1:0] MSG_PROBE    = 8'd1;
    localparam logic [MSG_W-1:0] MSG_DEFEND   = 8'd2;
    localparam logic [MSG_W-1:0] MSG_ANNOUNCE = 8'd3;

    // result status
    localparam logic STAT_MOVE = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    typedef struct packed {
        logic [MAC_W-1:0] key;
        logic [MAC_W-1:0] start;
        logic [LEN_W-1:0] len;
        claim_state_t     state;
        logic [TOT_W-1:0] probes;
        logic [TOT_W-1:0] conflicts;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic             status;
        logic [MAC_W-1:0] who;
        claim_state_t     from_state;
        claim_state_t     to_state;
        logic [MAC_W-1:0] range_base;
        logic [LEN_W-1:0] range_len;
        logic [TOT_W-1:0] probe_total;
        logic [TOT_W-1:0] conflict_total;
    } res_t;

    function automatic logic [TOT_W-1:0] sat_inc(input logic [TOT_W-1:0] v);
        return (&v) ? v : v + TOT_W'(1);
    endfunction

endpackage

>>> src/mct_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_in_if
// message channel: valid/ready with one decoded message per transfer
// ----------------------------------------------------------------------------
interface mct_in_if;
    logic                      valid;
    logic                      ready;
    logic [mct_pkg::MSG_W-1:0] msg_type;
    logic [mct_pkg::MAC_W-1:0] claimant_mac;
    logic [mct_pkg::MAC_W-1:0] req_start;
    logic [mct_pkg::LEN_W-1:0] req_count;

    modport source (output valid, output msg_type, output claimant_mac,
                    output req_start, output req_count, input ready);
    modport sink   (input valid, input msg_type, input claimant_mac,
                    input req_start, input req_count, output ready);
endinterface

>>> src/mct_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_out_if
// result channel: valid/ready with one state report per transfer
// ----------------------------------------------------------------------------
interface mct_out_if;
    logic                      valid;
    logic                      ready;
    logic                      status;
    logic [mct_pkg::MAC_W-1:0] who;
    mct_pkg::claim_state_t     from_state;
    mct_pkg::claim_state_t     to_state;
    logic [mct_pkg::MAC_W-1:0] range_base;
    logic [mct_pkg::LEN_W-1:0] range_len;
    logic [mct_pkg::TOT_W-1:0] probe_total;
    logic [mct_pkg::TOT_W-1:0] conflict_total;
    logic                      last;

    modport source (output valid, output status, output who, output from_state,
                    output to_state, output range_base, output range_len,
                    output probe_total, output conflict_total, output last,
                    input ready);
    modport sink   (input valid, input status, input who, input from_state,
                    input to_state, input range_base, input range_len,
                    input probe_total, input conflict_total, input last,
                    output ready);
endinterface

>>> src/mct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_ram
// generic ram, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module mct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/maap_claimant_state_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maap_claimant_state_tracker_unit
// claimant table with per-station claim state, range and saturating counters
// ----------------------------------------------------------------------------
// sequence: accept, a key scan over all TABLE_ENTRIES entries, update, then one
//   output transfer per result (up to two), held while the result channel stalls
// one message at a time, paced by the entry-by-entry key scan through the single
//   table read port; a new message is taken only once the sequencer is back in idle
// reset: control and entry valid bits cleared at once; table contents are
//   not cleared (unused until written), so no clearing pass is needed
// ----------------------------------------------------------------------------
module maap_claimant_state_tracker_unit (
    input  logic              clk,
    input  logic              rst_n,
    mct_in_if.sink            msg,
    mct_out_if.source         res
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_PROC = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;

    localparam int N = mct_pkg::TABLE_ENTRIES;

    // control
    logic [2:0]                    state_reg, state_next;
    logic [mct_pkg::CNT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                          cmp_vld_reg, cmp_vld_next;
    logic [mct_pkg::IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                          found_reg, found_next;
    logic [mct_pkg::IDX_W-1:0]     ent_idx_reg, ent_idx_next;
    logic                          free_vld_reg, free_vld_next;
    logic [mct_pkg::IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [N-1:0]                  valid_reg, valid_next;
    logic                          have_a_reg, have_a_next;
    logic                          have_b_reg, have_b_next;
    logic                          out_vld_reg, out_vld_next;

    // payload
    logic [mct_pkg::MSG_W-1:0]     msg_type_reg, msg_type_next;
    logic [mct_pkg::MAC_W-1:0]     mac_reg, mac_next;
    logic [mct_pkg::MAC_W-1:0]     start_reg, start_next;
    logic [mct_pkg::LEN_W-1:0]     len_reg, len_next;
    mct_pkg::row_t                 row_reg, row_next;
    mct_pkg::res_t                 res_a_reg, res_a_next;
    mct_pkg::res_t                 res_b_reg, res_b_next;
    mct_pkg::res_t                 out_res_reg, out_res_next;
    logic                          out_last_reg, out_last_next;

    // table port
    logic                          rd_en;
    logic [mct_pkg::IDX_W-1:0]     rd_addr;
    logic [mct_pkg::ROW_W-1:0]     rd_data;
    mct_pkg::row_t                 rd_row;
    logic                          wr_en;
    logic [mct_pkg::IDX_W-1:0]     wr_addr;
    mct_pkg::row_t                 wr_row;

    // update datapath
    mct_pkg::row_t                 cur_row;
    logic                          is_probe, is_def, is_ann;
    logic                          lost;
    mct_pkg::claim_state_t         st_mid;
    mct_pkg::claim_state_t         target;
    logic                          move_en;
    logic [mct_pkg::TOT_W-1:0]     probes_n, conf_n;
    logic                          out_space;

    mct_ram #(
        .WIDTH (mct_pkg::ROW_W),
        .DEPTH (N)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_row),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_row  = mct_pkg::row_t'(rd_data);
    assign rd_en   = (state_reg == S_SCAN) && (scan_cnt_reg < mct_pkg::CNT_W'(N));
    assign rd_addr = scan_cnt_reg[mct_pkg::IDX_W-1:0];

    // a claimant not in the table starts as unknown with cleared counters
    always_comb
    begin
        if (found_reg)
        begin
            cur_row = row_reg;
        end
        else
        begin
            cur_row.key       = mac_reg;
            cur_row.start     = start_reg;
            cur_row.len       = len_reg;
            cur_row.state     = mct_pkg::ST_UNKNOWN;
            cur_row.probes    = '0;
            cur_row.conflicts = '0;
        end
    end

    assign is_probe = (msg_type_reg == mct_pkg::MSG_PROBE);
    assign is_def   = (msg_type_reg == mct_pkg::MSG_DEFEND);
    assign is_ann   = (msg_type_reg == mct_pkg::MSG_ANNOUNCE);

    // probe for a changed range from a holder drops the claim first
    assign lost = is_probe
               && (cur_row.state == mct_pkg::ST_ACQUIRED
                   || cur_row.state == mct_pkg::ST_DEFENDING)
               && (cur_row.start != start_reg || cur_row.len != len_reg);

    assign st_mid   = lost ? mct_pkg::ST_LOST : cur_row.state;
    assign probes_n = is_probe ? mct_pkg::sat_inc(cur_row.probes) : cur_row.probes;
    assign conf_n   = is_def ? mct_pkg::sat_inc(cur_row.conflicts) : cur_row.conflicts;

    always_comb
    begin
        priority if (is_probe)
        begin
            target = mct_pkg::ST_PROBING;
        end
        else if (is_ann)
        begin
            target = mct_pkg::ST_ACQUIRED;
        end
        else
        begin
            target = mct_pkg::ST_DEFENDING;
        end
    end

    // ignored types and moves to the held state give no move report
    assign move_en = (is_probe || is_ann || is_def) && (st_mid != target);

    // write back in the update cycle unless the message is dropped
    assign wr_en   = (state_reg == S_PROC) && (found_reg || free_vld_reg);
    assign wr_addr = found_reg ? ent_idx_reg : free_idx_reg;

    always_comb
    begin
        wr_row.key       = cur_row.key;
        wr_row.start     = start_reg;
        wr_row.len       = len_reg;
        wr_row.state     = move_en ? target : st_mid;
        wr_row.probes    = probes_n;
        wr_row.conflicts = conf_n;
    end

    // output register is free when empty or being drained this cycle
    assign out_space = !out_vld_reg || res.ready;

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        found_next    = found_reg;
        ent_idx_next  = ent_idx_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        valid_next    = valid_reg;
        have_a_next   = have_a_reg;
        have_b_next   = have_b_reg;
        out_vld_next  = out_vld_reg && !res.ready;
        msg_type_next = msg_type_reg;
        mac_next      = mac_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        row_next      = row_reg;
        res_a_next    = res_a_reg;
        res_b_next    = res_b_reg;
        out_res_next  = out_res_reg;
        out_last_next = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (msg.valid)
                begin
                    msg_type_next = msg.msg_type;
                    mac_next      = msg.claimant_mac;
                    start_next    = msg.req_start;
                    len_next      = msg.req_count;
                    scan_cnt_next = '0;
                    cmp_vld_next  = 1'b0;
                    found_next    = 1'b0;
                    free_vld_next = 1'b0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // read one entry per cycle, compare the one read last cycle
                cmp_vld_next = rd_en;
                cmp_idx_next = rd_addr;
                if (rd_en)
                begin
                    scan_cnt_next = scan_cnt_reg + mct_pkg::CNT_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    if (valid_reg[cmp_idx_reg])
                    begin
                        if (!found_reg && rd_row.key == mac_reg)
                        begin
                            found_next   = 1'b1;
                            ent_idx_next = cmp_idx_reg;
                            row_next     = rd_row;
                        end
                    end
                    else if (!free_vld_reg)
                    begin
                        free_vld_next = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                end
                // the last entry is compared in the cycle its count is reached
                if (scan_cnt_reg == mct_pkg::CNT_W'(N))
                begin
                    state_next = S_PROC;
                end
            end

            S_PROC:
            begin
                res_a_next.status         = mct_pkg::STAT_MOVE;
                res_a_next.who            = cur_row.key;
                res_a_next.from_state     = cur_row.state;
                res_a_next.to_state       = mct_pkg::ST_LOST;
                res_a_next.range_base     = cur_row.start;
                res_a_next.range_len      = cur_row.len;
                res_a_next.probe_total    = cur_row.probes;
                res_a_next.conflict_total = cur_row.conflicts;
                if (found_reg || free_vld_reg)
                begin
                    res_b_next.status         = mct_pkg::STAT_MOVE;
                    res_b_next.who            = cur_row.key;
                    res_b_next.from_state     = st_mid;
                    res_b_next.to_state       = target;
                    res_b_next.range_base     = start_reg;
                    res_b_next.range_len      = len_reg;
                    res_b_next.probe_total    = probes_n;
                    res_b_next.conflict_total = conf_n;
                    have_a_next               = lost;
                    have_b_next               = move_en;
                    valid_next[wr_addr]       = 1'b1;
                    state_next = (lost || move_en) ? S_EMIT : S_IDLE;
                end
                else
                begin
                    // table full: message dropped, one report
                    res_b_next            = '0;
                    res_b_next.status     = mct_pkg::STAT_FULL;
                    res_b_next.who        = mac_reg;
                    have_a_next           = 1'b0;
                    have_b_next           = 1'b1;
                    state_next            = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_space)
                begin
                    out_vld_next = 1'b1;
                    if (have_a_reg)
                    begin
                        out_res_next  = res_a_reg;
                        out_last_next = !have_b_reg;
                        have_a_next   = 1'b0;
                        if (!have_b_reg)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        out_res_next  = res_b_reg;
                        out_last_next = 1'b1;
                        have_b_next   = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
            found_reg    <= 1'b0;
            ent_idx_reg  <= '0;
            free_vld_reg <= 1'b0;
            free_idx_reg <= '0;
            valid_reg    <= '0;
            have_a_reg   <= 1'b0;
            have_b_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            cmp_idx_reg  <= cmp_idx_next;
            found_reg    <= found_next;
            ent_idx_reg  <= ent_idx_next;
            free_vld_reg <= free_vld_next;
            free_idx_reg <= free_idx_next;
            valid_reg    <= valid_next;
            have_a_reg   <= have_a_next;
            have_b_reg   <= have_b_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_type_reg <= msg_type_next;
        mac_reg      <= mac_next;
        start_reg    <= start_next;
        len_reg      <= len_next;
        row_reg      <= row_next;
        res_a_reg    <= res_a_next;
        res_b_reg    <= res_b_next;
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
    end

    // channel drive
    assign msg.ready          = (state_reg == S_IDLE);
    assign res.valid          = out_vld_reg;
    assign res.status         = out_res_reg.status;
    assign res.who            = out_res_reg.who;
    assign res.from_state     = out_res_reg.from_state;
    assign res.to_state       = out_res_reg.to_state;
    assign res.range_base     = out_res_reg.range_base;
    assign res.range_len      = out_res_reg.range_len;
    assign res.probe_total    = out_res_reg.probe_total;
    assign res.conflict_total = out_res_reg.conflict_total;
    assign res.last           = out_last_reg;

    // one message at a time: no transfer right after an accepted one
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        msg.valid && msg.ready |=> !msg.ready)
        else $error("message accepted while previous one in flight");

    // a drop happens only when every entry is in use
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROC) && !found_reg && !free_vld_reg
        |-> ($countones(valid_reg) == N))
        else $error("table full reported with a free entry");

    // a matched entry is always a valid one
    a_match_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROC) && found_reg |-> valid_reg[ent_idx_reg])
        else $error("matched entry not valid");

    // a lost report is always followed by a second report of the same message
    a_lost_then_move: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && have_a_reg |-> have_b_reg)
        else $error("lost report without a following move");

endmodule
